@@ rtl/clamped_velocity_pid_core_defines.svh @@
// assertion macros used by clamped_velocity_pid_core.sv
`ifndef CLAMPED_VELOCITY_PID_CORE_DEFINES_SVH
`define CLAMPED_VELOCITY_PID_CORE_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define CVPID_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define CVPID_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/cvpid_pkg.sv @@
package cvpid_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ILIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd5;

    localparam int INTEG_W = 26;
    localparam int MEAS_W  = 16;

    localparam logic [15:0] KP_RESET   = 16'd7000;
    localparam logic [15:0] KI_RESET   = 16'd500;
    localparam logic [15:0] KD_RESET   = 16'd100;
    localparam logic [14:0] ELIM_RESET = 15'd1000;
    localparam logic [14:0] ILIM_RESET = 15'd10000;
    localparam logic [13:0] OLIM_RESET = 14'd10000;

    // limits pre-scaled to milli and micro units
    localparam logic [24:0] ILIM_M_RESET = 25'd10000000;
    localparam logic [23:0] OLIM_M_RESET = 24'd10000000;
    localparam logic [33:0] OLIM_U_RESET = 34'd10000000000;

    // derivative clamp of 30000 expressed in whole measurement steps
    localparam int DERIV_STEP_LIM = 30;

    // divide by one million as a shift by 6 and a divide by 15625
    localparam int          DIV_SHIFT   = 6;
    localparam logic [28:0] DIV_LO      = 29'd15625;
    localparam int          RECIP_SHIFT = 42;
    localparam logic [28:0] RECIP       = 29'd281474976;

    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic signed [MEAS_W-1:0]  prev;
    } state_t;

endpackage

@@ rtl/cvpid_state_mem.sv @@
module cvpid_state_mem #(
    parameter int AW = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  cvpid_pkg::state_t wr_data,
    output cvpid_pkg::state_t rd_data
);
    import cvpid_pkg::*;

    localparam int DEPTH = 1 << AW;

    state_t           state_mem [DEPTH];
    state_t           rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic             fwd;

    assign fwd = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= fwd ? wr_data : state_mem[rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= fwd || valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/clamped_velocity_pid_core.sv @@
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tuser channel, tdata target and measured velocity
// m_      | out | m_tvalid/m_tready  | tuser channel_out, tdata drive_current
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// one transaction per cycle sustained while m_tready stays high
// per-channel integral and last measurement sit in one memory, read when the input
// is accepted and written back as the item leaves stage 1, with write-to-read forwarding
// reset clears per-entry valid bits, so every channel starts from zero state
// a stalled m_tready backs up stage by stage; s_tready drops only when all stages are full
`include "clamped_velocity_pid_core_defines.svh"

module clamped_velocity_pid_core #(
    parameter int CHANNELS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // target_velocity, measured_velocity
    input  logic [1:0]                       s_tuser,   // channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // drive_current
    output logic [1:0]                       m_tuser,   // channel_out
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cvpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cvpid_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cvpid_pkg::*;

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STAGES = 7;

    // configuration
    logic [15:0] kp_reg, ki_reg, kd_reg;
    logic [14:0] elim_reg;
    logic [13:0] olim_reg;
    logic [24:0] ilim_m_reg;
    logic [23:0] olim_m_reg;
    logic [33:0] olim_u_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            kd_reg     <= KD_RESET;
            elim_reg   <= ELIM_RESET;
            olim_reg   <= OLIM_RESET;
            ilim_m_reg <= ILIM_M_RESET;
            olim_m_reg <= OLIM_M_RESET;
            olim_u_reg <= OLIM_U_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP:   kp_reg <= cfg_data;
                REG_KI:   ki_reg <= cfg_data;
                REG_KD:   kd_reg <= cfg_data;
                REG_ELIM: elim_reg <= cfg_data[14:0];
                REG_ILIM:
                begin
                    ilim_m_reg <= 25'(cfg_data[14:0]) * 25'd1000;
                end
                REG_OLIM:
                begin
                    olim_reg   <= cfg_data[13:0];
                    olim_m_reg <= 24'(cfg_data[13:0]) * 24'd1000;
                    olim_u_reg <= 34'(cfg_data[13:0]) * 34'd1000000;
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline flow control
    logic [STAGES:1]   v_reg;
    logic [STAGES+1:1] en;

    always_comb
    begin
        en[STAGES+1] = m_tready;
        for (int k = STAGES; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0: error clamp and state read
    logic signed [12:0] tgt0;
    logic signed [15:0] meas0;
    logic signed [16:0] diff0, elim_s;
    logic signed [15:0] err0;
    logic               ok0;

    assign tgt0   = $signed(s_tdata[12:0]);
    assign meas0  = $signed(s_tdata[28:13]);
    assign diff0  = 17'(tgt0) - 17'(meas0);
    assign elim_s = $signed({2'b00, elim_reg});
    assign ok0    = {30'd0, s_tuser} < 32'(CHANNELS);

    always_comb
    begin
        priority if (diff0 > elim_s)
            err0 = 16'(elim_s);
        else if (diff0 < -elim_s)
            err0 = 16'(-elim_s);
        else
            err0 = 16'(diff0);
    end

    // stage 1: integral update, derivative clamp and write-back
    logic [1:0]          ch1_reg;
    logic                ok1_reg;
    logic [AW-1:0]       addr1_reg;
    logic signed [15:0]  meas1_reg;
    logic signed [15:0]  err1_reg;
    state_t              st_rd, st_wr;
    logic                st_wr_en;
    logic signed [26:0]  isum1, ilim_s;
    logic signed [25:0]  integ1;
    logic signed [16:0]  dd1;
    logic signed [5:0]   dc1;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ch1_reg   <= s_tuser;
            ok1_reg   <= ok0;
            addr1_reg <= AW'(s_tuser);
            meas1_reg <= meas0;
            err1_reg  <= err0;
        end
    end

    cvpid_state_mem #(
        .AW (AW)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (en[1]),
        .rd_addr (AW'(s_tuser)),
        .wr_en   (st_wr_en),
        .wr_addr (addr1_reg),
        .wr_data (st_wr),
        .rd_data (st_rd)
    );

    assign isum1  = 27'(st_rd.integ) + 27'(err1_reg);
    assign ilim_s = $signed({2'b00, ilim_m_reg});
    assign dd1    = 17'(st_rd.prev) - 17'(meas1_reg);

    always_comb
    begin
        priority if (isum1 > ilim_s)
            integ1 = 26'(ilim_s);
        else if (isum1 < -ilim_s)
            integ1 = 26'(-ilim_s);
        else
            integ1 = 26'(isum1);
        priority if (dd1 > 17'(DERIV_STEP_LIM))
            dc1 = 6'(DERIV_STEP_LIM);
        else if (dd1 < -17'(DERIV_STEP_LIM))
            dc1 = -6'(DERIV_STEP_LIM);
        else
            dc1 = 6'(dd1);
    end

    assign st_wr_en    = v_reg[1] && ok1_reg && en[2];
    assign st_wr.integ = integ1;
    assign st_wr.prev  = meas1_reg;

    // stage 2: gain products
    logic [1:0]         ch2_reg;
    logic               ok2_reg;
    logic signed [15:0] err2_reg;
    logic signed [25:0] integ2_reg;
    logic signed [5:0]  dc2_reg;
    logic signed [16:0] kp_s, ki_s, kd_s;
    logic signed [32:0] pm2;
    logic signed [42:0] im2;
    logic signed [21:0] dm2;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ch2_reg    <= ch1_reg;
            ok2_reg    <= ok1_reg;
            err2_reg   <= err1_reg;
            integ2_reg <= integ1;
            dc2_reg    <= dc1;
        end
    end

    assign kp_s = $signed({1'b0, kp_reg});
    assign ki_s = $signed({1'b0, ki_reg});
    assign kd_s = $signed({1'b0, kd_reg});
    assign pm2  = 33'(kp_s) * 33'(err2_reg);
    assign im2  = 43'(ki_s) * 43'(integ2_reg);
    assign dm2  = 22'(kd_s) * 22'(dc2_reg);

    // stage 3: p clamp and sum in micro units
    logic [1:0]         ch3_reg;
    logic               ok3_reg;
    logic signed [32:0] pm3_reg;
    logic signed [42:0] im3_reg;
    logic signed [21:0] dm3_reg;
    logic signed [32:0] olim_m_s;
    logic signed [24:0] pc3;
    logic signed [43:0] sum3;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ch3_reg <= ch2_reg;
            ok3_reg <= ok2_reg;
            pm3_reg <= pm2;
            im3_reg <= im2;
            dm3_reg <= dm2;
        end
    end

    assign olim_m_s = $signed({9'd0, olim_m_reg});

    always_comb
    begin
        priority if (pm3_reg > olim_m_s)
            pc3 = 25'(olim_m_s);
        else if (pm3_reg < -olim_m_s)
            pc3 = 25'(-olim_m_s);
        else
            pc3 = 25'(pm3_reg);
    end

    assign sum3 = 44'(pc3) * 44'sd1000 + 44'(im3_reg) + 44'(dm3_reg) * 44'sd1000000;

    // stage 4: magnitude and saturation
    logic [1:0]         ch4_reg;
    logic               ok4_reg;
    logic signed [43:0] sum4_reg;
    logic               neg4, sat4;
    logic [43:0]        mag4;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ch4_reg  <= ch3_reg;
            ok4_reg  <= ok3_reg;
            sum4_reg <= sum3;
        end
    end

    assign neg4 = sum4_reg[43];
    assign mag4 = neg4 ? 44'(-sum4_reg) : 44'(sum4_reg);
    assign sat4 = mag4 >= {10'd0, olim_u_reg};

    // stage 5: reciprocal estimate
    logic [1:0]  ch5_reg;
    logic        ok5_reg, neg5_reg, sat5_reg;
    logic [27:0] x5_reg;
    logic [56:0] prod5;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ch5_reg  <= ch4_reg;
            ok5_reg  <= ok4_reg;
            neg5_reg <= neg4;
            sat5_reg <= sat4;
            x5_reg   <= mag4[33:DIV_SHIFT];
        end
    end

    assign prod5 = 57'(x5_reg) * 57'(RECIP);

    // stage 6: quotient correction and result
    logic [1:0]         ch6_reg;
    logic               ok6_reg, neg6_reg, sat6_reg;
    logic [27:0]        x6_reg;
    logic [14:0]        qe6_reg;
    logic [28:0]        rem6;
    logic [14:0]        q6;
    logic signed [14:0] olim_s, drive6;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            ch6_reg  <= ch5_reg;
            ok6_reg  <= ok5_reg;
            neg6_reg <= neg5_reg;
            sat6_reg <= sat5_reg;
            x6_reg   <= x5_reg;
            qe6_reg  <= prod5[56:RECIP_SHIFT];
        end
    end

    assign rem6   = 29'(x6_reg) - 29'(qe6_reg) * DIV_LO;
    assign q6     = (rem6 >= DIV_LO) ? qe6_reg + 15'd1 : qe6_reg;
    assign olim_s = $signed({1'b0, olim_reg});

    always_comb
    begin
        priority if (!ok6_reg)
            drive6 = '0;
        else if (sat6_reg)
            drive6 = neg6_reg ? -olim_s : olim_s;
        else
            drive6 = neg6_reg ? -$signed(q6) : $signed(q6);
    end

    // stage 7: output register
    logic [1:0]         ch7_reg;
    logic signed [14:0] drive7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            ch7_reg    <= ch6_reg;
            drive7_reg <= drive6;
        end
    end

    assign m_tuser = ch7_reg;
    assign m_tdata = {1'b0, drive7_reg};

    `CVPID_CHECK(full_stall_a, !s_tready |-> (&v_reg && !m_tready), "input stalled with room")
    `CVPID_CHECK_NEXT(state_hold_a, v_reg[1] && !en[2], $stable(st_rd), "held state read changed")
    `CVPID_CHECK(deriv_range_a, v_reg[2] |-> (dc2_reg <= 6'sd30 && dc2_reg >= -6'sd30), "deriv out of range")
    `CVPID_CHECK(quot_range_a, (v_reg[6] && ok6_reg && !sat6_reg) |-> !q6[14], "quotient overflow")

endmodule

@@ tb/clamped_velocity_pid_core_test.sv @@
`timescale 1ns / 1ps

module clamped_velocity_pid_core_test;

    import cvpid_pkg::*;

    typedef struct {
        logic [1:0]         ch;
        logic signed [14:0] drive;
    } drive_result_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    class drive_current_predictor;
        localparam int     CHANNELS    = 4;
        localparam longint MILLI       = 1000;
        localparam longint MICRO       = 1000000;
        localparam longint DERIV_CLAMP = 30000;

        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [14:0] err_clamp;
        logic [14:0] integ_clamp_units;
        logic [13:0] out_clamp;

        longint integ_sum[CHANNELS];
        longint prev_speed[CHANNELS];

        drive_result_t pending[$];
        int mismatches;
        int checked;
        int out_clamps;
        int integ_clamps;

        function new();
            kp_gain           = KP_RESET;
            ki_gain           = KI_RESET;
            kd_gain           = KD_RESET;
            err_clamp         = ELIM_RESET;
            integ_clamp_units = ILIM_RESET;
            out_clamp         = OLIM_RESET;
            foreach (integ_sum[i])
            begin
                integ_sum[i]  = 0;
                prev_speed[i] = 0;
            end
            mismatches   = 0;
            checked      = 0;
            out_clamps   = 0;
            integ_clamps = 0;
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KP:   kp_gain           = data;
                REG_KI:   ki_gain           = data;
                REG_KD:   kd_gain           = data;
                REG_ELIM: err_clamp         = data[14:0];
                REG_ILIM: integ_clamp_units = data[14:0];
                REG_OLIM: out_clamp         = data[13:0];
                default:  ;
            endcase
        endfunction

        function void step_channel(logic [1:0] ch, logic signed [12:0] tgt,
                                   logic signed [15:0] meas);
            drive_result_t res;
            longint olim;
            longint err;
            longint deriv;
            longint sum_raw;
            longint integ;
            longint p6;
            longint i6;
            longint d6;
            longint q;
            res.ch    = ch;
            res.drive = '0;
            if (ch < CHANNELS)
            begin
                olim    = longint'(out_clamp);
                err     = clamp(longint'(tgt) - longint'(meas), longint'(err_clamp));
                deriv   = clamp((prev_speed[ch] - longint'(meas)) * MILLI, DERIV_CLAMP);
                sum_raw = integ_sum[ch] + err;
                integ   = clamp(sum_raw, longint'(integ_clamp_units) * MILLI);
                if (integ != sum_raw)
                    integ_clamps++;
                p6 = clamp(longint'(kp_gain) * err * MILLI, olim * MICRO);
                i6 = longint'(ki_gain) * integ;
                d6 = longint'(kd_gain) * deriv * MILLI;
                q  = (p6 + i6 + d6) / MICRO;
                if (q > olim || q < -olim)
                    out_clamps++;
                q = clamp(q, olim);
                integ_sum[ch]  = integ;
                prev_speed[ch] = longint'(meas);
                res.drive      = q[14:0];
            end
            pending.push_back(res);
        endfunction

        function void check_drive(logic [1:0] ch, logic signed [14:0] drive);
            drive_result_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual channel %0d drive %0d",
                         $time, ch, drive);
                mismatches++;
                return;
            end
            exp_r = pending.pop_front();
            if (ch !== exp_r.ch)
            begin
                $display("%0t channel_out mismatch: expected %0d, actual %0d",
                         $time, exp_r.ch, ch);
                mismatches++;
            end
            if (drive !== exp_r.drive)
            begin
                $display("%0t drive_current mismatch on channel %0d: expected %0d, actual %0d",
                         $time, exp_r.ch, exp_r.drive, drive);
                mismatches++;
            end
        endfunction
    endclass

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_CYCLES     = 80;
    localparam int TAIL_CYCLES     = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_CHUNK = 34;
    localparam int CHUNKS          = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // target_velocity, measured_velocity
    logic [1:0]            s_tuser;   // channel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // drive_current
    logic [1:0]            m_tuser;   // channel_out
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drive_current_predictor sb;
    reg_write_t             reg_batch[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_start;
    int hold_left;
    int cycle_count;
    int settings_loaded;

    clamped_velocity_pid_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("clamped_velocity_pid_core_test: FAIL");
            $finish;
        end
    end

    // receiver side, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_register(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
                sb.check_drive(m_tuser, m_tdata[14:0]);
            if (s_tvalid && s_tready)
                sb.step_channel(s_tuser, s_tdata[12:0], s_tdata[28:13]);
        end
    end

    // entered and left at a falling edge; valid stays high for the next transaction
    task automatic send_item(input logic [1:0] ch, input logic [12:0] tgt,
                             input logic [15:0] meas);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {3'b000, meas, tgt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int t;
        int m;
        if ($urandom_range(0, 99) < 85)
            t = int'($urandom_range(0, 6000)) - 3000;
        else
            t = int'($urandom_range(0, 8191)) - 4096;
        if ($urandom_range(0, 99) < 60)
            m = t + int'($urandom_range(0, 200)) - 100;
        else
            m = int'($urandom_range(0, 65535)) - 32768;
        send_item(2'($urandom_range(0, 3)), t[12:0], m[15:0]);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic flush_reg_batch();
        reg_write_t wr;
        while (reg_batch.size() != 0)
        begin
            wr = reg_batch.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.idx;
            cfg_data  <= wr.data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [15:0] pick_value(logic [15:0] maxv);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return maxv;
            2:       return 16'($urandom_range(0, 20));
            3:       return 16'($urandom_range(0, 5000));
            4:       return 16'($urandom_range(0, maxv));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic pick_random_settings();
        reg_batch.push_back('{REG_KP, pick_value(16'hFFFF)});
        reg_batch.push_back('{REG_KI, pick_value(16'hFFFF)});
        reg_batch.push_back('{REG_KD, pick_value(16'hFFFF)});
        reg_batch.push_back('{REG_ELIM, pick_value(16'h7FFF)});
        reg_batch.push_back('{REG_ILIM, pick_value(16'h7FFF)});
        reg_batch.push_back('{REG_OLIM, pick_value(16'h3FFF)});
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_start      = 1'b0;
        hold_left       = 0;
        cycle_count     = 0;
        settings_loaded = 0;
        sb              = new();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gains and limits
        send_item(2'd0, 13'sd0, 16'sd0);
        send_item(2'd0, 13'sd3000, 16'sd0);
        send_item(2'd1, -13'sd3000, 16'sd0);
        send_item(2'd2, 13'sd4095, -16'sd32768);
        send_item(2'd3, -13'sd4096, 16'sd32767);
        send_item(2'd2, 13'sd0, 16'sd32767);
        send_item(2'd3, 13'sd100, 16'sd100);
        send_item(2'd0, 13'sd3000, 16'sd2999);
        settle();

        // maximum gains, masked limits, writes to unused indexes
        reg_batch.push_back('{REG_KP, 16'hFFFF});
        reg_batch.push_back('{REG_KI, 16'hFFFF});
        reg_batch.push_back('{REG_KD, 16'hFFFF});
        reg_batch.push_back('{REG_ELIM, 16'hFFFF});
        reg_batch.push_back('{REG_ILIM, 16'hFFFF});
        reg_batch.push_back('{REG_OLIM, 16'hFFFF});
        reg_batch.push_back('{REG_SPARE_0, 16'h0000});
        reg_batch.push_back('{REG_SPARE_1, 16'h1234});
        flush_reg_batch();
        send_item(2'd0, 13'sd4095, -16'sd32768);
        send_item(2'd1, -13'sd4096, 16'sd32767);
        send_item(2'd2, 13'sd0, 16'sd0);
        send_item(2'd3, -13'sd1, 16'sd1);
        send_item(2'd0, -13'sd4096, 16'sd32767);
        settle();

        // every limit and gain at zero
        reg_batch.push_back('{REG_KP, 16'd0});
        reg_batch.push_back('{REG_KI, 16'd0});
        reg_batch.push_back('{REG_KD, 16'd0});
        reg_batch.push_back('{REG_ELIM, 16'd0});
        reg_batch.push_back('{REG_ILIM, 16'd0});
        reg_batch.push_back('{REG_OLIM, 16'd0});
        flush_reg_batch();
        send_item(2'd0, 13'sd3000, -16'sd32768);
        send_item(2'd1, -13'sd3000, 16'sd32767);
        send_item(2'd2, 13'sd4095, 16'sd0);
        send_item(2'd3, 13'sd0, -16'sd32768);
        settle();

        // integral only, saturating at one unit
        reg_batch.push_back('{REG_KI, 16'hFFFF});
        reg_batch.push_back('{REG_ELIM, 16'h7FFF});
        reg_batch.push_back('{REG_ILIM, 16'd1});
        reg_batch.push_back('{REG_OLIM, 16'h3FFF});
        flush_reg_batch();
        send_item(2'd1, 13'sd3000, 16'sd0);
        send_item(2'd1, 13'sd3000, 16'sd0);
        send_item(2'd1, 13'sd3000, 16'sd0);
        send_item(2'd1, -13'sd3000, 16'sd0);
        settle();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < CHUNKS; chunk++)
            begin
                pick_random_settings();
                flush_reg_batch();
                if (mode == 2 && chunk == 1)
                begin
                    @(posedge clk);
                    hold_start = 1'b1;
                    @(negedge clk);
                end
                repeat (ITEMS_PER_CHUNK) send_random_item();
                settle();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d transactions under %0d register settings",
                 sb.checked, settings_loaded);
        $display("%0d outputs hit the output clamp, %0d steps hit the integral clamp",
                 sb.out_clamps, sb.integ_clamps);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("clamped_velocity_pid_core_test: PASS");
        else
            $display("clamped_velocity_pid_core_test: FAIL");
        $finish;
    end

endmodule
